// ----- rtl/core/gic_pkg.sv -----
`default_nettype none

package gic_pkg;

  // Field widths of the request and result items.
  localparam int ReqTypeW   = 2;
  localparam int ButtonW    = 16;
  localparam int AxisW      = 16;
  localparam int AmountW    = 16;
  localparam int RumbleTW   = 24;
  localparam int NumAxes    = 4;

  // Configuration register widths and reset values.
  localparam int CoeffW     = 16;
  localparam int PeriodW    = 20;
  localparam int TimeoutW   = 20;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 20;

  localparam logic [CoeffW-1:0]   CoeffReset   = 16'd9040;
  localparam logic [PeriodW-1:0]  PeriodReset  = 20'd16000;
  localparam logic [TimeoutW-1:0] TimeoutReset = 20'd1000000;

  localparam int ButtonBitsDefault = 16;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CfgFilterCoeff    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTickPeriod     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgGestureTimeout = 2'd2;

  // Request codes.
  localparam logic [ReqTypeW-1:0] ReqTick        = 2'd0;
  localparam logic [ReqTypeW-1:0] ReqRumbleLeft  = 2'd1;
  localparam logic [ReqTypeW-1:0] ReqRumbleRight = 2'd2;

  // Gesture quadrant codes, visited clockwise.
  localparam logic [1:0] QuadUpRight   = 2'd0;
  localparam logic [1:0] QuadDownRight = 2'd1;
  localparam logic [1:0] QuadDownLeft  = 2'd2;
  localparam logic [1:0] QuadUpLeft    = 2'd3;

  typedef logic signed [AxisW-1:0] axis_t;

endpackage

`default_nettype wire

// ----- rtl/core/gic_if.sv -----
`default_nettype none

interface gic_req_if import gic_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ReqTypeW-1:0] req_type;
  logic [ButtonW-1:0]  buttons;
  axis_t               left_x;
  axis_t               left_y;
  axis_t               right_x;
  axis_t               right_y;
  logic                connected;
  logic [AmountW-1:0]  rumble_amount;
  logic [RumbleTW-1:0] rumble_time;

  modport source (
    output valid, req_type, buttons, left_x, left_y, right_x, right_y, connected,
           rumble_amount, rumble_time,
    input  ready
  );
  modport sink (
    input  valid, req_type, buttons, left_x, left_y, right_x, right_y, connected,
           rumble_amount, rumble_time,
    output ready
  );
endinterface

interface gic_res_if import gic_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ButtonW-1:0] pressed_mask;
  logic [ButtonW-1:0] released_mask;
  axis_t              left_x_filtered;
  axis_t              left_y_filtered;
  axis_t              right_x_filtered;
  axis_t              right_y_filtered;
  logic               rotation_done;
  logic [AmountW-1:0] left_rumble;
  logic [AmountW-1:0] right_rumble;

  modport source (
    output valid, pressed_mask, released_mask, left_x_filtered, left_y_filtered,
           right_x_filtered, right_y_filtered, rotation_done, left_rumble, right_rumble,
    input  ready
  );
  modport sink (
    input  valid, pressed_mask, released_mask, left_x_filtered, left_y_filtered,
           right_x_filtered, right_y_filtered, rotation_done, left_rumble, right_rumble,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/gamepad_input_conditioner_top.sv -----
`default_nettype none

// Gamepad input conditioner.
// Request items arrive on req_i and every accepted item returns exactly one
// result item on res_o. A sample tick with connected high updates the button
// edge masks, the four low-pass filtered stick axes, the left stick rotation
// gesture and the two rumble countdowns; a disconnected tick or an unused
// request code leaves all state alone. Rumble requests load one channel.
// Each result shows the state after its item.
// The input register feeds the state registers, which double as the result
// register; an item's result is registered once res_o is free to advance.
// Throughput is one item per cycle while res_o does not stall; the filter
// multiply, the timer subtracts and the gesture compares all sit in the
// single stage between them. When res_o stalls, the input register still
// takes one more item and then req_i.ready drops until the result is taken;
// nothing is lost. Reset clears all state and loads the configuration
// defaults. The user must write the configuration port only while no item
// is in flight; the block itself does not enforce this.
module gamepad_input_conditioner_top import gic_pkg::*; #(
  parameter int BUTTON_BITS = ButtonBitsDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  gic_req_if.sink                  req_i,
  gic_res_if.source                res_o
);

  localparam int UsedBits = (BUTTON_BITS < ButtonW) ? BUTTON_BITS : ButtonW;

  // Configuration registers.
  logic [CoeffW-1:0]   coeff_q;
  logic [PeriodW-1:0]  period_q;
  logic [TimeoutW-1:0] timeout_q;

  // Input register.
  logic                s1_valid_q;
  logic [ReqTypeW-1:0] s1_req_q;
  logic [UsedBits-1:0] s1_buttons_q;
  axis_t               s1_axis_q [NumAxes];
  logic                s1_conn_q;
  logic [AmountW-1:0]  s1_amount_q;
  logic [RumbleTW-1:0] s1_time_q;

  // State, which is also the result payload.
  logic                res_valid_q;
  logic [UsedBits-1:0] prev_q, prev_d;
  logic [UsedBits-1:0] pressed_q, pressed_d;
  logic [UsedBits-1:0] released_q, released_d;
  axis_t               axis_q [NumAxes];
  axis_t               axis_d [NumAxes];
  logic [1:0]          quad_q, quad_d;
  logic [TimeoutW-1:0] gtimer_q, gtimer_d;
  logic [AmountW-1:0]  level_q [2];
  logic [AmountW-1:0]  level_d [2];
  logic [RumbleTW-1:0] rtimer_q [2];
  logic [RumbleTW-1:0] rtimer_d [2];

  logic advance;
  logic fire;
  logic tick;
  logic x_pos, x_npos, x_neg, y_pos, y_npos, y_neg, y_nneg;

  assign advance     = !res_valid_q || res_o.ready;
  assign req_i.ready = !s1_valid_q || advance;
  assign fire        = advance && s1_valid_q;
  assign tick        = fire && (s1_req_q == ReqTick) && s1_conn_q;

  for (genvar g = 0; g < NumAxes; g++) begin : g_lane
    gic_lp_filter u_filter (
      .coeff_i  (coeff_q),
      .state_i  (axis_q[g]),
      .sample_i (s1_axis_q[g]),
      .state_o  (axis_d[g])
    );
  end

  // Left stick sign tests.
  always_comb begin
    x_neg  = s1_axis_q[0][AxisW-1];
    y_neg  = s1_axis_q[1][AxisW-1];
    x_npos = x_neg || (s1_axis_q[0] == '0);
    y_npos = y_neg || (s1_axis_q[1] == '0);
    x_pos  = !x_npos;
    y_pos  = !y_npos;
    y_nneg = !y_neg;
  end

  always_comb begin
    prev_d     = prev_q;
    pressed_d  = pressed_q;
    released_d = released_q;
    quad_d     = quad_q;
    gtimer_d   = gtimer_q;
    level_d    = level_q;
    rtimer_d   = rtimer_q;

    if (tick) begin
      pressed_d  = ~prev_q & s1_buttons_q;
      released_d = prev_q & ~s1_buttons_q;
      prev_d     = s1_buttons_q;

      if (x_pos && y_pos) begin
        quad_d   = QuadUpRight;
        gtimer_d = timeout_q;
      end
      if (gtimer_d != '0) begin
        gtimer_d = (gtimer_d > period_q) ? gtimer_d - period_q : '0;
        if (quad_d == QuadUpLeft) begin
          quad_d = QuadUpRight;
        end
        if (x_pos && y_npos && quad_d == QuadUpRight) begin
          quad_d = QuadDownRight;
        end
        if (x_npos && y_neg && quad_d == QuadDownRight) begin
          quad_d = QuadDownLeft;
        end
        if (x_neg && y_nneg && quad_d == QuadDownLeft) begin
          quad_d = QuadUpLeft;
        end
      end else begin
        quad_d = QuadUpRight;
      end

      for (int i = 0; i < 2; i++) begin
        if (rtimer_q[i] != '0) begin
          rtimer_d[i] = (rtimer_q[i] > RumbleTW'(period_q)) ?
                        rtimer_q[i] - RumbleTW'(period_q) : '0;
        end else begin
          level_d[i] = '0;
        end
      end
    end else if (fire && s1_req_q == ReqRumbleLeft) begin
      level_d[0]  = s1_amount_q;
      rtimer_d[0] = s1_time_q;
    end else if (fire && s1_req_q == ReqRumbleRight) begin
      level_d[1]  = s1_amount_q;
      rtimer_d[1] = s1_time_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q     <= CoeffReset;
      period_q    <= PeriodReset;
      timeout_q   <= TimeoutReset;
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      prev_q      <= '0;
      pressed_q   <= '0;
      released_q  <= '0;
      quad_q      <= QuadUpRight;
      gtimer_q    <= '0;
      for (int i = 0; i < NumAxes; i++) begin
        axis_q[i] <= '0;
      end
      for (int i = 0; i < 2; i++) begin
        level_q[i]  <= '0;
        rtimer_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgFilterCoeff:    coeff_q   <= cfg_wdata_i[CoeffW-1:0];
          CfgTickPeriod:     period_q  <= cfg_wdata_i[PeriodW-1:0];
          CfgGestureTimeout: timeout_q <= cfg_wdata_i[TimeoutW-1:0];
          default: ;
        endcase
      end
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (advance) begin
        res_valid_q <= s1_valid_q;
      end
      prev_q     <= prev_d;
      pressed_q  <= pressed_d;
      released_q <= released_d;
      quad_q     <= quad_d;
      gtimer_q   <= gtimer_d;
      level_q    <= level_d;
      rtimer_q   <= rtimer_d;
      if (tick) begin
        axis_q <= axis_d;
      end
    end
  end

  // Input payload register, loaded on acceptance.
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_req_q     <= req_i.req_type;
      s1_buttons_q <= req_i.buttons[UsedBits-1:0];
      s1_axis_q[0] <= req_i.left_x;
      s1_axis_q[1] <= req_i.left_y;
      s1_axis_q[2] <= req_i.right_x;
      s1_axis_q[3] <= req_i.right_y;
      s1_conn_q    <= req_i.connected;
      s1_amount_q  <= req_i.rumble_amount;
      s1_time_q    <= req_i.rumble_time;
    end
  end

  assign res_o.valid            = res_valid_q;
  assign res_o.pressed_mask     = ButtonW'(pressed_q);
  assign res_o.released_mask    = ButtonW'(released_q);
  assign res_o.left_x_filtered  = axis_q[0];
  assign res_o.left_y_filtered  = axis_q[1];
  assign res_o.right_x_filtered = axis_q[2];
  assign res_o.right_y_filtered = axis_q[3];
  assign res_o.rotation_done    = (quad_q == QuadUpLeft);
  assign res_o.left_rumble      = level_q[0];
  assign res_o.right_rumble     = level_q[1];

  // A button cannot be pressed and released in the same tick.
  a_edges_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pressed_q & released_q) == '0)
    else $error("pressed and released masks overlap");

  // Gesture completion lasts for exactly one connected tick.
  a_done_one_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick && quad_q == QuadUpLeft) |=> (quad_q != QuadUpLeft))
    else $error("rotation gesture held past one tick");

  // A waiting result is not disturbed by later items.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_o.ready) |=>
      ($stable(quad_q) && $stable(pressed_q) && $stable(axis_q[0]) &&
       $stable(level_q[0]) && $stable(level_q[1])))
    else $error("state changed while result stalled");

  // A rumble level is only cleared by a tick that found its timer expired.
  a_rumble_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (level_q[0] != '0 && rtimer_q[0] != '0 && !(fire && s1_req_q == ReqRumbleLeft))
      |=> (level_q[0] == $past(level_q[0])))
    else $error("left rumble level changed before its timer expired");

endmodule

`default_nettype wire

// ----- rtl/core/gic_lp_filter.sv -----
`default_nettype none

// One low-pass step f + a*(x - f), rounded to nearest with ties upward,
// saturated to the Q1.15 range.
module gic_lp_filter import gic_pkg::*; (
  input  wire logic [CoeffW-1:0] coeff_i,
  input  wire axis_t             state_i,
  input  wire axis_t             sample_i,
  output axis_t                  state_o
);

  logic signed [AxisW:0]     diff;
  logic signed [2*AxisW+1:0] prod;
  logic signed [2*AxisW+1:0] prod_rnd;
  logic signed [AxisW+1:0]   step;
  logic signed [AxisW+2:0]   sum;

  always_comb begin
    diff     = {sample_i[AxisW-1], sample_i} - {state_i[AxisW-1], state_i};
    prod     = (2*AxisW+2)'($signed({1'b0, coeff_i})) * (2*AxisW+2)'(diff);
    prod_rnd = prod + (2*AxisW+2)'(32768);
    // Taking the upper bits is an arithmetic shift right by 16 (floor).
    step     = prod_rnd[2*AxisW+1:CoeffW];
    sum      = {{3{state_i[AxisW-1]}}, state_i} + {step[AxisW+1], step};
    if (sum > (AxisW+3)'(32767)) begin
      state_o = 16'sh7FFF;
    end else if (sum < -(AxisW+3)'(32768)) begin
      state_o = 16'sh8000;
    end else begin
      state_o = sum[AxisW-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/tb_gamepad_input_conditioner_top.sv -----
`timescale 1ns / 100ps

module tb_gamepad_input_conditioner_top;
  import gic_pkg::*;

  // The block ignores this request code; it has no name in the package.
  localparam logic [ReqTypeW-1:0] ReqUnused = 2'd3;
  localparam int StallLimit = 2000;
  localparam int LongHold   = 300;

  typedef struct packed {
    logic [ReqTypeW-1:0] kind;
    logic [ButtonW-1:0]  buttons;
    axis_t               lx;
    axis_t               ly;
    axis_t               rx;
    axis_t               ry;
    logic                connected;
    logic [AmountW-1:0]  amount;
    logic [RumbleTW-1:0] dur;
  } pad_req_t;

  typedef struct packed {
    logic [ButtonW-1:0] pressed;
    logic [ButtonW-1:0] released;
    axis_t              lxf;
    axis_t              lyf;
    axis_t              rxf;
    axis_t              ryf;
    logic               done;
    logic [AmountW-1:0] rumble_l;
    logic [AmountW-1:0] rumble_r;
  } pad_out_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  gic_req_if req_bus ();
  gic_res_if res_bus ();

  gamepad_input_conditioner_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_bus),
    .res_o      (res_bus)
  );

  // Predicted block state and configuration.
  logic [CoeffW-1:0]   cfg_coeff;
  logic [PeriodW-1:0]  cfg_period;
  logic [TimeoutW-1:0] cfg_timeout;
  logic [ButtonW-1:0]  st_prev_btn;
  logic [ButtonW-1:0]  st_pressed;
  logic [ButtonW-1:0]  st_released;
  axis_t               st_filt [NumAxes];
  logic [1:0]          st_quad;
  logic [TimeoutW-1:0] st_gtimer;
  logic [AmountW-1:0]  st_rlevel [2];
  logic [RumbleTW-1:0] st_rtimer [2];

  pad_req_t request_q [$];
  pad_out_t conditioned_q [$];
  pad_req_t on_bus;
  pad_out_t want;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_req_id;
  int hold_seen_id;
  int hold_left;
  int err_cnt;
  int quiet_cycles;
  int gest_aim;
  logic [ButtonW-1:0] last_buttons;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic reset_pad_model();
    int i;
    cfg_coeff   = CoeffReset;
    cfg_period  = PeriodReset;
    cfg_timeout = TimeoutReset;
    st_prev_btn = '0;
    st_pressed  = '0;
    st_released = '0;
    for (i = 0; i < NumAxes; i++) st_filt[i] = '0;
    st_quad   = QuadUpRight;
    st_gtimer = '0;
    for (i = 0; i < 2; i++) begin
      st_rlevel[i] = '0;
      st_rtimer[i] = '0;
    end
  endtask

  function automatic pad_out_t condition_request(pad_req_t r);
    int       ax [NumAxes];
    longint   prod;
    longint   incr;
    int       sum;
    int       i;
    pad_out_t o;
    case (r.kind)
      ReqTick: begin
        if (r.connected) begin
          st_pressed  = ~st_prev_btn & r.buttons;
          st_released = st_prev_btn & ~r.buttons;
          st_prev_btn = r.buttons;
          ax[0] = r.lx;
          ax[1] = r.ly;
          ax[2] = r.rx;
          ax[3] = r.ry;
          // One pole low-pass, rounded half up, clamped to the Q1.15 range.
          for (i = 0; i < NumAxes; i++) begin
            prod = longint'(cfg_coeff) * longint'(ax[i] - int'(st_filt[i]));
            incr = (prod + 64'sd32768) >>> 16;
            sum  = int'(st_filt[i]) + int'(incr);
            if (sum > 32767) sum = 32767;
            if (sum < -32768) sum = -32768;
            st_filt[i] = axis_t'(sum);
          end
          if (ax[0] > 0 && ax[1] > 0) begin
            st_quad   = QuadUpRight;
            st_gtimer = cfg_timeout;
          end
          if (st_gtimer != 0) begin
            st_gtimer = (st_gtimer > cfg_period) ? st_gtimer - cfg_period : '0;
            if (st_quad == QuadUpLeft) st_quad = QuadUpRight;
            if (ax[0] > 0 && ax[1] <= 0 && st_quad == QuadUpRight) st_quad = QuadDownRight;
            if (ax[0] <= 0 && ax[1] < 0 && st_quad == QuadDownRight) st_quad = QuadDownLeft;
            if (ax[0] < 0 && ax[1] >= 0 && st_quad == QuadDownLeft) st_quad = QuadUpLeft;
          end else begin
            st_quad = QuadUpRight;
          end
          for (i = 0; i < 2; i++) begin
            if (st_rtimer[i] != 0) begin
              st_rtimer[i] = (st_rtimer[i] > RumbleTW'(cfg_period)) ?
                             st_rtimer[i] - RumbleTW'(cfg_period) : '0;
            end else begin
              st_rlevel[i] = '0;
            end
          end
        end
      end
      ReqRumbleLeft: begin
        st_rlevel[0] = r.amount;
        st_rtimer[0] = r.dur;
      end
      ReqRumbleRight: begin
        st_rlevel[1] = r.amount;
        st_rtimer[1] = r.dur;
      end
      default: ;
    endcase
    o.pressed  = st_pressed;
    o.released = st_released;
    o.lxf      = st_filt[0];
    o.lyf      = st_filt[1];
    o.rxf      = st_filt[2];
    o.ryf      = st_filt[3];
    o.done     = (st_quad == QuadUpLeft);
    o.rumble_l = st_rlevel[0];
    o.rumble_r = st_rlevel[1];
    return o;
  endfunction

  // Mostly uniform, with an occasional pick of either end of the range.
  function automatic int pick_between(int lo, int hi);
    if ($urandom_range(7) == 0) return ($urandom_range(1) != 0) ? lo : hi;
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic pad_req_t random_request();
    pad_req_t r;
    int       pick;
    r.kind      = ReqTick;
    r.buttons   = ButtonW'($urandom);
    r.lx        = axis_t'($urandom);
    r.ly        = axis_t'($urandom);
    r.rx        = axis_t'($urandom);
    r.ry        = axis_t'($urandom);
    r.connected = 1'b1;
    r.amount    = AmountW'($urandom);
    r.dur       = RumbleTW'($urandom);
    pick = $urandom_range(99);
    if (pick < 60) begin
      // Walk the left stick through the clockwise quadrant sequence.
      case (gest_aim)
        0: begin
          r.lx = axis_t'(pick_between(1, 32767));
          r.ly = axis_t'(pick_between(1, 32767));
        end
        1: begin
          r.lx = axis_t'(pick_between(1, 32767));
          r.ly = axis_t'(pick_between(-32768, 0));
        end
        2: begin
          r.lx = axis_t'(pick_between(-32768, 0));
          r.ly = axis_t'(pick_between(-32768, -1));
        end
        default: begin
          r.lx = axis_t'(pick_between(-32768, -1));
          r.ly = axis_t'(pick_between(0, 32767));
        end
      endcase
      if ($urandom_range(9) < 8) gest_aim = (gest_aim + 1) % 4;
      else if ($urandom_range(1) != 0) gest_aim = 0;
      else gest_aim = $urandom_range(3);
      if ($urandom_range(1) != 0) begin
        r.buttons = last_buttons ^ (ButtonW'($urandom) & ButtonW'($urandom) & ButtonW'($urandom));
      end
    end else if (pick < 70) begin
      r.connected = 1'b0;
    end else if (pick < 85) begin
      r.kind = ($urandom_range(1) != 0) ? ReqRumbleLeft : ReqRumbleRight;
      case ($urandom_range(3))
        0: r.dur = '0;
        1: r.dur = RumbleTW'(cfg_period * $urandom_range(4, 1));
        2: ;
        default: r.dur = RumbleTW'(cfg_period * $urandom_range(3, 1) + $urandom_range(2));
      endcase
    end else if (pick < 90) begin
      r.kind = ReqUnused;
    end else begin
      r.connected = 1'($urandom_range(1));
    end
    if (r.kind == ReqTick && r.connected) last_buttons = r.buttons;
    return r;
  endfunction

  task automatic push_tick(input logic [ButtonW-1:0] b, input int lx, input int ly,
                           input int rx, input int ry, input logic conn);
    pad_req_t r;
    r           = '0;
    r.kind      = ReqTick;
    r.buttons   = b;
    r.lx        = axis_t'(lx);
    r.ly        = axis_t'(ly);
    r.rx        = axis_t'(rx);
    r.ry        = axis_t'(ry);
    r.connected = conn;
    request_q.push_back(r);
  endtask

  task automatic push_rumble(input logic [ReqTypeW-1:0] kind, input logic [AmountW-1:0] amount,
                             input logic [RumbleTW-1:0] dur);
    pad_req_t r;
    r        = random_request();
    r.kind   = kind;
    r.amount = amount;
    r.dur    = dur;
    request_q.push_back(r);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CfgFilterCoeff:    cfg_coeff = val[CoeffW-1:0];
      CfgTickPeriod:     cfg_period = val[PeriodW-1:0];
      CfgGestureTimeout: cfg_timeout = val[TimeoutW-1:0];
      default: ;
    endcase
  endtask

  // Waits until every queued item has gone in and every result has come out.
  task automatic wait_quiet();
    while (request_q.size() != 0 || req_bus.valid || conditioned_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [CoeffW-1:0] coeff, input logic [PeriodW-1:0] period,
                           input logic [TimeoutW-1:0] timeout, input int send_pct,
                           input int recv_pct, input int n_items, input bit long_hold);
    int i;
    wait_quiet();
    write_cfg(CfgFilterCoeff, CfgDataW'(coeff));
    write_cfg(CfgTickPeriod, CfgDataW'(period));
    write_cfg(CfgGestureTimeout, CfgDataW'(timeout));
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (i = 0; i < n_items / 2; i++) request_q.push_back(random_request());
    if (long_hold) hold_req_id++;
    // The sender pauses here until the block has drained completely.
    wait_quiet();
    for (i = n_items / 2; i < n_items; i++) request_q.push_back(random_request());
  endtask

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_bus.valid <= 1'b0;
    end else begin
      if (req_bus.valid && req_bus.ready) conditioned_q.push_back(condition_request(on_bus));
      if (!req_bus.valid || req_bus.ready) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = request_q.pop_front();
          req_bus.req_type      <= on_bus.kind;
          req_bus.buttons       <= on_bus.buttons;
          req_bus.left_x        <= on_bus.lx;
          req_bus.left_y        <= on_bus.ly;
          req_bus.right_x       <= on_bus.rx;
          req_bus.right_y       <= on_bus.ry;
          req_bus.connected     <= on_bus.connected;
          req_bus.rumble_amount <= on_bus.amount;
          req_bus.rumble_time   <= on_bus.dur;
          req_bus.valid         <= 1'b1;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int expv, input int actv);
    if (expv != actv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      err_cnt++;
    end
  endtask

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (conditioned_q.size() == 0) begin
          $error("result item arrived with nothing expected");
          err_cnt++;
        end else begin
          want = conditioned_q.pop_front();
          check_field("pressed_mask", want.pressed, res_bus.pressed_mask);
          check_field("released_mask", want.released, res_bus.released_mask);
          check_field("left_x_filtered", want.lxf, res_bus.left_x_filtered);
          check_field("left_y_filtered", want.lyf, res_bus.left_y_filtered);
          check_field("right_x_filtered", want.rxf, res_bus.right_x_filtered);
          check_field("right_y_filtered", want.ryf, res_bus.right_y_filtered);
          check_field("rotation_done", want.done, res_bus.rotation_done);
          check_field("left_rumble", want.rumble_l, res_bus.left_rumble);
          check_field("right_rumble", want.rumble_r, res_bus.right_rumble);
        end
      end
      if (hold_seen_id != hold_req_id) begin
        hold_seen_id = hold_req_id;
        hold_left    = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("[gamepad_input_conditioner_top] ERROR");
        $finish;
      end
    end
  end

  initial begin
    pad_req_t odd;
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_idx               = '0;
    cfg_wdata             = '0;
    req_bus.valid         = 1'b0;
    req_bus.req_type      = ReqTick;
    req_bus.buttons       = '0;
    req_bus.left_x        = '0;
    req_bus.left_y        = '0;
    req_bus.right_x       = '0;
    req_bus.right_y       = '0;
    req_bus.connected     = 1'b0;
    req_bus.rumble_amount = '0;
    req_bus.rumble_time   = '0;
    res_bus.ready         = 1'b0;
    send_idle_pct         = 15;
    recv_idle_pct         = 57;
    hold_req_id           = 0;
    hold_seen_id          = 0;
    hold_left             = 0;
    err_cnt               = 0;
    quiet_cycles          = 0;
    gest_aim              = 0;
    last_buttons          = '0;
    reset_pad_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Full clockwise rotation from the extremes, then the tick after completion.
    push_tick(16'hFFFF, 32767, 32767, 32767, 32767, 1'b1);
    push_tick(16'h0000, 32767, 0, -32768, -32768, 1'b1);
    push_tick(16'hA5A5, 0, -32768, 32767, -32768, 1'b1);
    push_tick(16'h5A5A, -32768, 0, -32768, 32767, 1'b1);
    push_tick(16'h5A5A, -1, 1, 0, 0, 1'b1);
    // A disconnected tick and an unused code leave everything alone.
    push_tick(16'hFFFF, 32767, -32768, 12345, -12345, 1'b0);
    odd      = random_request();
    odd.kind = ReqUnused;
    request_q.push_back(odd);
    push_rumble(ReqRumbleLeft, 16'hFFFF, 24'd32000);
    push_rumble(ReqRumbleRight, 16'h8001, 24'hFFFFFF);
    // Left rumble runs out after two ticks and clears on the third.
    push_tick(16'h0001, 0, 0, 0, 0, 1'b1);
    push_tick(16'h8000, 0, 0, 0, 0, 1'b1);
    push_tick(16'h0000, 0, 0, 0, 0, 1'b1);
    push_rumble(ReqRumbleLeft, 16'h1234, 24'd0);
    push_tick(16'hFFFF, -32768, -32768, -32768, -32768, 1'b1);
    push_tick(16'h0000, 32767, 32767, 32767, 32767, 1'b1);

    run_phase(16'd65535, 20'd1, 20'd1048575, 15, 57, 90, 1'b1);
    run_phase(16'd0, 20'd1000000, 20'd1, 15, 57, 80, 1'b0);
    run_phase(16'd12345, 20'd0, 20'd0, 57, 15, 80, 1'b0);
    run_phase(16'd9040, 20'd16000, 20'd100000, 57, 15, 90, 1'b0);
    run_phase(16'd40000, 20'd1048575, 20'd1048575, 0, 0, 80, 1'b0);
    run_phase(16'd1, 20'd3, 20'd40, 0, 0, 80, 1'b0);
    wait_quiet();
    repeat (10) @(posedge clk);

    if (err_cnt == 0) begin
      $display("[gamepad_input_conditioner_top] OK");
    end else begin
      $display("[gamepad_input_conditioner_top] ERROR");
    end
    $finish;
  end

endmodule
